// ----- rtl/link_supervisor_seq_gap_scan_unit_defines.svh -----
// assertion macros shared by the link supervisor rtl
`ifndef LINK_SUPERVISOR_SEQ_GAP_SCAN_UNIT_DEFINES_SVH
`define LINK_SUPERVISOR_SEQ_GAP_SCAN_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define LSSGS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked at every edge, reset included
`define LSSGS_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define LSSGS_ASSERT(lbl, prop, msg)
`define LSSGS_CHECK(lbl, prop, msg)
`endif

`endif

// ----- rtl/lssgs_pkg.sv -----
package lssgs_pkg;

    localparam int TOP_CHANNEL_DEF = 13;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_TYPE_CODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TYPE_CODE      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_FRAME_LENGTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_FRAME_LENGTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFLINE_TIMEOUT_MS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOP_INTERVAL_MS    = 3'd5;

    // register reset values
    localparam logic [7:0]  RST_DATA_TYPE_CODE     = 8'd1;
    localparam logic [7:0]  RST_ACK_TYPE_CODE      = 8'd2;
    localparam logic [7:0]  RST_DATA_FRAME_LENGTH  = 8'd16;
    localparam logic [7:0]  RST_ACK_FRAME_LENGTH   = 8'd2;
    localparam logic [31:0] RST_OFFLINE_TIMEOUT_MS = 32'd3000;
    localparam logic [31:0] RST_HOP_INTERVAL_MS    = 32'd200;

    // status event codes
    localparam logic [1:0] STATUS_NONE     = 2'd0;
    localparam logic [1:0] STATUS_RESTORED = 2'd1;
    localparam logic [1:0] STATUS_LOST     = 2'd2;

    localparam logic [31:0] CLOCK_VALID_SECONDS = 32'd1000000000;

    typedef struct packed {
        logic [7:0]  data_type_code;
        logic [7:0]  ack_type_code;
        logic [7:0]  data_frame_length;
        logic [7:0]  ack_frame_length;
        logic [31:0] offline_timeout_ms;
        logic [31:0] hop_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] now_ms;
        logic [7:0]  frame_type;
        logic [7:0]  frame_length;
        logic [7:0]  hub_channel;
        logic [7:0]  frame_sequence;
        logic [31:0] hub_epoch_seconds;
        logic [47:0] source_address;
    } item_t;

    typedef struct packed {
        logic        link_up;
        logic [1:0]  status_event;
        logic        deliver_data;
        logic [7:0]  reply_sequence;
        logic        ack_seen;
        logic        tune_request;
        logic [3:0]  tune_channel;
        logic        clock_set;
        logic [31:0] dropped_total;
        logic        hub_learned;
        logic        unknown_frame;
    } result_t;

endpackage

// ----- rtl/lssgs_cfg.sv -----
module lssgs_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lssgs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lssgs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output lssgs_pkg::cfg_t                     cfg
);

    lssgs_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.data_type_code     <= lssgs_pkg::RST_DATA_TYPE_CODE;
            cfg_reg.ack_type_code      <= lssgs_pkg::RST_ACK_TYPE_CODE;
            cfg_reg.data_frame_length  <= lssgs_pkg::RST_DATA_FRAME_LENGTH;
            cfg_reg.ack_frame_length   <= lssgs_pkg::RST_ACK_FRAME_LENGTH;
            cfg_reg.offline_timeout_ms <= lssgs_pkg::RST_OFFLINE_TIMEOUT_MS;
            cfg_reg.hop_interval_ms    <= lssgs_pkg::RST_HOP_INTERVAL_MS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lssgs_pkg::CFG_DATA_TYPE_CODE:     cfg_reg.data_type_code     <= cfg_wdata[7:0];
                lssgs_pkg::CFG_ACK_TYPE_CODE:      cfg_reg.ack_type_code      <= cfg_wdata[7:0];
                lssgs_pkg::CFG_DATA_FRAME_LENGTH:  cfg_reg.data_frame_length  <= cfg_wdata[7:0];
                lssgs_pkg::CFG_ACK_FRAME_LENGTH:   cfg_reg.ack_frame_length   <= cfg_wdata[7:0];
                lssgs_pkg::CFG_OFFLINE_TIMEOUT_MS: cfg_reg.offline_timeout_ms <= cfg_wdata;
                lssgs_pkg::CFG_HOP_INTERVAL_MS:    cfg_reg.hop_interval_ms    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/lssgs_engine.sv -----
`include "link_supervisor_seq_gap_scan_unit_defines.svh"

module lssgs_engine #(
    parameter int TOP_CHANNEL = lssgs_pkg::TOP_CHANNEL_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  lssgs_pkg::item_t    item,
    input  lssgs_pkg::cfg_t     cfg,
    output lssgs_pkg::result_t  res
);

    localparam logic [3:0] TOP_CH = 4'(TOP_CHANNEL);

    logic        connected_reg,       connected_next;
    logic [31:0] last_data_time_reg,  last_data_time_next;
    logic [31:0] last_hop_time_reg,   last_hop_time_next;
    logic [3:0]  scan_channel_reg,    scan_channel_next;
    logic [3:0]  locked_channel_reg,  locked_channel_next;
    logic [3:0]  pending_channel_reg, pending_channel_next;
    logic [7:0]  prev_sequence_reg,   prev_sequence_next;
    logic        sequence_valid_reg,  sequence_valid_next;
    logic [31:0] drop_counter_reg,    drop_counter_next;
    logic [47:0] hub_address_reg,     hub_address_next;
    logic        hub_known_reg,       hub_known_next;

    logic        frame_present;
    logic        is_data;
    logic        is_ack;
    logic        chan_ok;
    logic [7:0]  gap;
    logic [7:0]  gap_minus_one;
    logic [31:0] since_data;
    logic [31:0] since_hop;
    logic [3:0]  hop_channel;
    logic        do_lock;

    always_comb begin
        frame_present = (item.frame_length != 8'd0);
        is_data = frame_present
                  && (item.frame_type == cfg.data_type_code)
                  && (item.frame_length == cfg.data_frame_length);
        is_ack  = frame_present && !is_data
                  && (item.frame_type == cfg.ack_type_code)
                  && (item.frame_length == cfg.ack_frame_length);
        chan_ok = (item.hub_channel != 8'd0)
                  && (item.hub_channel <= {4'd0, TOP_CH})
                  && (item.hub_channel != {4'd0, locked_channel_reg});
        gap           = 8'(item.frame_sequence - prev_sequence_reg);
        gap_minus_one = 8'(gap - 8'd1);
        since_data    = 32'(item.now_ms - last_data_time_reg);
        since_hop     = 32'(item.now_ms - last_hop_time_reg);
        hop_channel   = 4'(scan_channel_reg + 4'd1);
        if ((hop_channel > TOP_CH) || (hop_channel == 4'd0)) begin
            hop_channel = 4'd1;
        end
        do_lock = (pending_channel_reg != 4'd0)
                  && (pending_channel_reg != locked_channel_reg);

        connected_next       = connected_reg;
        last_data_time_next  = last_data_time_reg;
        last_hop_time_next   = last_hop_time_reg;
        scan_channel_next    = scan_channel_reg;
        locked_channel_next  = locked_channel_reg;
        pending_channel_next = pending_channel_reg;
        prev_sequence_next   = prev_sequence_reg;
        sequence_valid_next  = sequence_valid_reg;
        drop_counter_next    = drop_counter_reg;
        hub_address_next     = hub_address_reg;
        hub_known_next       = hub_known_reg;

        res                = '0;
        res.status_event   = lssgs_pkg::STATUS_NONE;

        if (!item.kind) begin
            if (is_data) begin
                if (chan_ok) begin
                    pending_channel_next = item.hub_channel[3:0];
                end
                last_data_time_next = item.now_ms;
                if (!connected_reg) begin
                    connected_next   = 1'b1;
                    res.status_event = lssgs_pkg::STATUS_RESTORED;
                end
                res.clock_set = (item.hub_epoch_seconds > lssgs_pkg::CLOCK_VALID_SECONDS);
                if (!hub_known_reg) begin
                    hub_address_next = item.source_address;
                    hub_known_next   = 1'b1;
                    res.hub_learned  = 1'b1;
                end
                if (sequence_valid_reg) begin
                    if (gap != 8'd1) begin
                        drop_counter_next = 32'(drop_counter_reg + {24'd0, gap_minus_one});
                    end
                end else begin
                    sequence_valid_next = 1'b1;
                end
                prev_sequence_next = item.frame_sequence;
                res.deliver_data   = 1'b1;
                res.reply_sequence = item.frame_sequence;
            end else if (is_ack) begin
                res.ack_seen       = 1'b1;
                res.reply_sequence = item.frame_sequence;
            end else if (frame_present) begin
                res.unknown_frame = 1'b1;
            end
        end else begin
            // channel lock requested by the hub
            if (do_lock) begin
                locked_channel_next  = pending_channel_reg;
                pending_channel_next = 4'd0;
                sequence_valid_next  = 1'b0;
                res.tune_request     = 1'b1;
                res.tune_channel     = pending_channel_reg;
            end
            if (connected_reg) begin
                if (since_data > cfg.offline_timeout_ms) begin
                    connected_next      = 1'b0;
                    locked_channel_next = 4'd0;
                    scan_channel_next   = TOP_CH;
                    res.status_event    = lssgs_pkg::STATUS_LOST;
                end
            end else if (since_hop > cfg.hop_interval_ms) begin
                last_hop_time_next = item.now_ms;
                scan_channel_next  = hop_channel;
                res.tune_request   = 1'b1;
                res.tune_channel   = hop_channel;
            end
        end

        res.link_up       = connected_next;
        res.dropped_total = drop_counter_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            connected_reg       <= 1'b0;
            last_data_time_reg  <= 32'd0;
            last_hop_time_reg   <= 32'd0;
            scan_channel_reg    <= TOP_CH;
            locked_channel_reg  <= 4'd0;
            pending_channel_reg <= 4'd0;
            prev_sequence_reg   <= 8'd0;
            sequence_valid_reg  <= 1'b0;
            drop_counter_reg    <= 32'd0;
            hub_address_reg     <= 48'd0;
            hub_known_reg       <= 1'b0;
        end else if (step) begin
            connected_reg       <= connected_next;
            last_data_time_reg  <= last_data_time_next;
            last_hop_time_reg   <= last_hop_time_next;
            scan_channel_reg    <= scan_channel_next;
            locked_channel_reg  <= locked_channel_next;
            pending_channel_reg <= pending_channel_next;
            prev_sequence_reg   <= prev_sequence_next;
            sequence_valid_reg  <= sequence_valid_next;
            drop_counter_reg    <= drop_counter_next;
            hub_address_reg     <= hub_address_next;
            hub_known_reg       <= hub_known_next;
        end
    end

    `LSSGS_ASSERT(a_scan_in_range, (scan_channel_reg != 4'd0) && (scan_channel_reg <= TOP_CH), "scan channel out of range")
    `LSSGS_ASSERT(a_pending_not_locked, (pending_channel_reg != 4'd0) |-> (pending_channel_reg != locked_channel_reg), "pending channel equals locked channel")
    `LSSGS_ASSERT(a_drops_only_on_data, !(step && res.deliver_data) |=> $stable(drop_counter_reg), "drop counter moved without a data frame")

endmodule

// ----- rtl/link_supervisor_seq_gap_scan_unit.sv -----
// a result is computed from the input register and captured in the result register
//   once its input transaction is accepted and the result register is free or drains
// throughput: one transaction per cycle while the result channel does not stall, set by
//   the input register feeding the combinational supervisor update into the result register
// reset (aresetn low, synchronous): both handshake stages empty, supervisor
//   state back to link down / scan at top channel, registers to their defaults
`include "link_supervisor_seq_gap_scan_unit_defines.svh"

module link_supervisor_seq_gap_scan_unit #(
    parameter int TOP_CHANNEL = lssgs_pkg::TOP_CHANNEL_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // register write port
    input  logic                                cfg_wr_en,
    input  logic [lssgs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lssgs_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // input channel: received frame or poll
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [31:0]                         s_now_ms,
    input  logic [7:0]                          s_frame_type,
    input  logic [7:0]                          s_frame_length,
    input  logic [7:0]                          s_hub_channel,
    input  logic [7:0]                          s_frame_sequence,
    input  logic [31:0]                         s_hub_epoch_seconds,
    input  logic [47:0]                         s_source_address,

    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_link_up,
    output logic [1:0]                          m_status_event,
    output logic                                m_deliver_data,
    output logic [7:0]                          m_reply_sequence,
    output logic                                m_ack_seen,
    output logic                                m_tune_request,
    output logic [3:0]                          m_tune_channel,
    output logic                                m_clock_set,
    output logic [31:0]                         m_dropped_total,
    output logic                                m_hub_learned,
    output logic                                m_unknown_frame
);

    lssgs_pkg::cfg_t    cfg;
    lssgs_pkg::item_t   in_item_reg;
    lssgs_pkg::result_t step_res;
    lssgs_pkg::result_t out_res_reg;

    logic in_valid_reg,  in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic in_fire;
    logic advance;

    // configuration registers
    lssgs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // the held transaction moves on whenever the result register is free or drains
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_item_reg.kind              <= s_kind;
            in_item_reg.now_ms            <= s_now_ms;
            in_item_reg.frame_type        <= s_frame_type;
            in_item_reg.frame_length      <= s_frame_length;
            in_item_reg.hub_channel       <= s_hub_channel;
            in_item_reg.frame_sequence    <= s_frame_sequence;
            in_item_reg.hub_epoch_seconds <= s_hub_epoch_seconds;
            in_item_reg.source_address    <= s_source_address;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    // supervisor state and per-transaction decision
    lssgs_engine #(
        .TOP_CHANNEL (TOP_CHANNEL)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    assign m_valid          = out_valid_reg;
    assign m_link_up        = out_res_reg.link_up;
    assign m_status_event   = out_res_reg.status_event;
    assign m_deliver_data   = out_res_reg.deliver_data;
    assign m_reply_sequence = out_res_reg.reply_sequence;
    assign m_ack_seen       = out_res_reg.ack_seen;
    assign m_tune_request   = out_res_reg.tune_request;
    assign m_tune_channel   = out_res_reg.tune_channel;
    assign m_clock_set      = out_res_reg.clock_set;
    assign m_dropped_total  = out_res_reg.dropped_total;
    assign m_hub_learned    = out_res_reg.hub_learned;
    assign m_unknown_frame  = out_res_reg.unknown_frame;

    // a retune always names a real channel, and no channel shows without a retune
    `LSSGS_ASSERT(a_tune_channel_consistent,
        m_valid |-> (m_tune_request == (m_tune_channel != 4'd0)),
        "tune channel disagrees with tune request")
    // a restore event leaves the link up, a loss leaves it down
    `LSSGS_ASSERT(a_status_matches_link,
        m_valid && (m_status_event != lssgs_pkg::STATUS_NONE)
            |-> (m_link_up == (m_status_event == lssgs_pkg::STATUS_RESTORED)),
        "status event disagrees with link state")
    // reset empties the result stage
    `LSSGS_CHECK(a_reset_clears_result, !aresetn |=> !m_valid, "result valid after reset")

endmodule
